// ===== rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cau_pkg
// Shared beat types, opcodes and status codes of the complex arithmetic unit.
// ---------------------------------------------------------------------------
package cau_pkg;

  // width of every operand and result part
  localparam int DATA_W = 16;

  // opcodes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EQ  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SAT     = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic                     equal;
    logic [1:0]               status;
  } out_beat_t;

endpackage

// ===== rtl/cau_div_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cau_div_step
// One registered restoring-division step: tries den << SHIFT against the
// running remainder and sets quotient bit SHIFT.
// ---------------------------------------------------------------------------
module cau_div_step #(
  parameter int RW    = 40,
  parameter int DW    = 32,
  parameter int QW    = 16,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_i,
  input  logic [QW-1:0] q_i,
  input  logic [DW-1:0] den_i,
  output logic [RW-1:0] rem_o,
  output logic [QW-1:0] q_o
);

  localparam int CW = RW + DW;

  logic [CW-1:0] trial;
  logic [CW-1:0] rem_ext;
  logic          fits;
  logic [RW-1:0] rem_nxt;
  logic [QW-1:0] q_nxt;
  logic [RW-1:0] rem_r;
  logic [QW-1:0] q_r;

  // compare and conditional subtract
  always_comb begin
    trial   = CW'(den_i) << SHIFT;
    rem_ext = CW'(rem_i);
    fits    = rem_ext >= trial;
    rem_nxt = fits ? RW'(rem_ext - trial) : rem_i;
    q_nxt   = fits ? (q_i | (QW'(1) << SHIFT)) : q_i;
  end

  // step register, payload only
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU: add, subtract, multiply, divide and compare on
// signed fixed-point operands, with saturation and status.
// ---------------------------------------------------------------------------
// The unit accepts one beat per cycle while it is not stalled and returns one
// result beat per input beat, in order, through one stage of multipliers, one
// of sums, one of divide setup, one stage per quotient bit of the restoring
// divider, and the output register. Every opcode takes the same path. When
// the output beat is stalled the whole pipeline holds and in_stall is raised.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cau_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cau_pkg::out_beat_t  out_data
);

  localparam int W  = cau_pkg::DATA_W;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int RW = 2 * W + F;
  localparam int CW = RW + PW;

  localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  typedef struct packed {
    logic                 v;
    logic [2:0]           op;
    logic                 eq;
    logic                 bz;
    logic signed [SW-1:0] alt_re;
    logic signed [SW-1:0] alt_im;
    logic                 neg_re;
    logic                 neg_im;
    logic                 ov_re;
    logic                 ov_im;
    logic [PW-1:0]        den;
  } side_t;

  logic adv;
  logic out_valid_r;

  // whole pipeline moves unless the output beat is held
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ---- stage 1: products, add/sub, compare ----
  logic                 s1_v_r;
  logic [2:0]           s1_op_r;
  logic                 s1_eq_r;
  logic                 s1_bz_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [W:0]    as_re_r, as_im_r;
  logic signed [W:0]    as_re_nxt, as_im_nxt;

  always_comb begin
    if (in_data.op == cau_pkg::OP_SUB) begin
      as_re_nxt = (W+1)'(in_data.a_re) - (W+1)'(in_data.b_re);
      as_im_nxt = (W+1)'(in_data.a_im) - (W+1)'(in_data.b_im);
    end else begin
      as_re_nxt = (W+1)'(in_data.a_re) + (W+1)'(in_data.b_re);
      as_im_nxt = (W+1)'(in_data.a_im) + (W+1)'(in_data.b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r <= in_data.op;
      s1_eq_r <= (in_data.a_re == in_data.b_re) && (in_data.a_im == in_data.b_im);
      s1_bz_r <= (in_data.b_re == '0) && (in_data.b_im == '0);
      p_rr_r  <= PW'(in_data.a_re) * PW'(in_data.b_re);
      p_ii_r  <= PW'(in_data.a_im) * PW'(in_data.b_im);
      p_ri_r  <= PW'(in_data.a_re) * PW'(in_data.b_im);
      p_ir_r  <= PW'(in_data.a_im) * PW'(in_data.b_re);
      p_bb_r  <= PW'(in_data.b_re) * PW'(in_data.b_re);
      p_cc_r  <= PW'(in_data.b_im) * PW'(in_data.b_im);
      as_re_r <= as_re_nxt;
      as_im_r <= as_im_nxt;
    end
  end

  // ---- stage 2: cross sums, divide numerators and denominator ----
  logic signed [SW-1:0] mre_sum, mim_sum, nre, nim;
  logic [SW-1:0]        mag_re_full, mag_im_full;
  side_t                s2_nxt, s2_r;
  logic [PW-1:0]        s2_mag_re_r, s2_mag_im_r;

  always_comb begin
    mre_sum     = SW'(p_rr_r) - SW'(p_ii_r);
    mim_sum     = SW'(p_ri_r) + SW'(p_ir_r);
    nre         = SW'(p_rr_r) + SW'(p_ii_r);
    nim         = SW'(p_ir_r) - SW'(p_ri_r);
    mag_re_full = nre[SW-1] ? -nre : nre;
    mag_im_full = nim[SW-1] ? -nim : nim;
    s2_nxt        = '0;
    s2_nxt.v      = s1_v_r;
    s2_nxt.op     = s1_op_r;
    s2_nxt.eq     = s1_eq_r;
    s2_nxt.bz     = s1_bz_r;
    s2_nxt.neg_re = nre[SW-1];
    s2_nxt.neg_im = nim[SW-1];
    s2_nxt.den    = $unsigned(p_bb_r) + $unsigned(p_cc_r);
    case (s1_op_r)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        s2_nxt.alt_re = SW'(as_re_r);
        s2_nxt.alt_im = SW'(as_im_r);
      end
      cau_pkg::OP_MUL: begin
        s2_nxt.alt_re = mre_sum >>> F;
        s2_nxt.alt_im = mim_sum >>> F;
      end
      default: begin
        s2_nxt.alt_re = '0;
        s2_nxt.alt_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.v <= 1'b0;
    end else if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mag_re_r <= mag_re_full[PW-1:0];
      s2_mag_im_r <= mag_im_full[PW-1:0];
    end
  end

  // ---- stage 3: overflow check and divider setup ----
  side_t         side_r [W+1];
  side_t         s3_nxt;
  logic [RW-1:0] rem_re [W+1];
  logic [RW-1:0] rem_im [W+1];
  logic [W-1:0]  q_re   [W+1];
  logic [W-1:0]  q_im   [W+1];
  logic [RW-1:0] rem_re_r, rem_im_r;
  logic [CW-1:0] den_lim;

  // quotient overflows W bits when mag << F >= den << W
  always_comb begin
    den_lim       = CW'(s2_r.den) << W;
    s3_nxt        = s2_r;
    s3_nxt.ov_re  = (CW'(s2_mag_re_r) << F) >= den_lim;
    s3_nxt.ov_im  = (CW'(s2_mag_im_r) << F) >= den_lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0].v <= 1'b0;
    end else if (adv) begin
      side_r[0] <= s3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_re_r <= RW'(s2_mag_re_r) << F;
      rem_im_r <= RW'(s2_mag_im_r) << F;
    end
  end

  assign rem_re[0] = rem_re_r;
  assign rem_im[0] = rem_im_r;
  assign q_re[0]   = '0;
  assign q_im[0]   = '0;

  // ---- divider stages, one quotient bit each, msb first ----
  for (genvar j = 0; j < W; j++) begin : g_div
    cau_div_step #(.RW(RW), .DW(PW), .QW(W), .SHIFT(W - 1 - j)) u_step_re (
      .clk   (clk),
      .en    (adv),
      .rem_i (rem_re[j]),
      .q_i   (q_re[j]),
      .den_i (side_r[j].den),
      .rem_o (rem_re[j+1]),
      .q_o   (q_re[j+1])
    );
    cau_div_step #(.RW(RW), .DW(PW), .QW(W), .SHIFT(W - 1 - j)) u_step_im (
      .clk   (clk),
      .en    (adv),
      .rem_i (rem_im[j]),
      .q_i   (q_im[j]),
      .den_i (side_r[j].den),
      .rem_o (rem_im[j+1]),
      .q_o   (q_im[j+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[j+1].v <= 1'b0;
      end else if (adv) begin
        side_r[j+1] <= side_r[j];
      end
    end
  end

  // ---- final stage: select, saturate, status ----
  function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] v,
                                        input logic force_ov,
                                        input logic neg);
    logic [W:0] r;
    if (force_ov) begin
      r = {1'b1, neg ? SMIN[W-1:0] : SMAX[W-1:0]};
    end else if (v > SMAX) begin
      r = {1'b1, SMAX[W-1:0]};
    end else if (v < SMIN) begin
      r = {1'b1, SMIN[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  side_t                fin;
  logic signed [SW-1:0] dv_re, dv_im;
  logic [W:0]           sr_re, sr_im;
  cau_pkg::out_beat_t   out_nxt;
  cau_pkg::out_beat_t   out_data_r;

  always_comb begin
    fin     = side_r[W];
    dv_re   = fin.neg_re ? -$signed(SW'(q_re[W])) : $signed(SW'(q_re[W]));
    dv_im   = fin.neg_im ? -$signed(SW'(q_im[W])) : $signed(SW'(q_im[W]));
    sr_re   = '0;
    sr_im   = '0;
    out_nxt = '0;
    case (fin.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
        sr_re = sat_fn(fin.alt_re, 1'b0, 1'b0);
        sr_im = sat_fn(fin.alt_im, 1'b0, 1'b0);
        out_nxt.res_re = sr_re[W-1:0];
        out_nxt.res_im = sr_im[W-1:0];
        out_nxt.status = (sr_re[W] || sr_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_DIV: begin
        if (fin.bz) begin
          out_nxt.status = cau_pkg::ST_DIVZERO;
        end else begin
          sr_re = sat_fn(dv_re, fin.ov_re, fin.neg_re);
          sr_im = sat_fn(dv_im, fin.ov_im, fin.neg_im);
          out_nxt.res_re = sr_re[W-1:0];
          out_nxt.res_im = sr_im[W-1:0];
          out_nxt.status = (sr_re[W] || sr_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      cau_pkg::OP_EQ: begin
        out_nxt.equal  = fin.eq;
        out_nxt.status = cau_pkg::ST_OK;
      end
      default: begin
        out_nxt.status = cau_pkg::ST_INVALID;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/cau_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ---------------------------------------------------------------------------
module cau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input cau_pkg::out_beat_t out_data
);

  // held result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // divide by zero gives zero parts
  a_divzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == cau_pkg::ST_DIVZERO |->
      out_data.res_re == '0 && out_data.res_im == '0 && !out_data.equal)
    else $error("divide by zero beat has nonzero fields");

  // equal flag only on a clean compare
  a_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.equal |->
      out_data.status == cau_pkg::ST_OK && out_data.res_re == '0 && out_data.res_im == '0)
    else $error("equal flag with nonzero parts or status");

  // invalid opcode gives an empty result
  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == cau_pkg::ST_INVALID |->
      out_data.res_re == '0 && out_data.res_im == '0 && !out_data.equal)
    else $error("invalid opcode beat has nonzero fields");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
